// ----- rtl/kfc_pkg.sv -----
`default_nettype none

package kfc_pkg;

   localparam int MAX_KMER_DEFAULT   = 8;
   localparam int COUNT_BITS_DEFAULT = 20;

   localparam int SYMBOL_BITS = 8;
   localparam int INDEX_BITS  = 16;
   localparam int OUT_BITS    = 20;
   localparam int KLEN_BITS   = 4;

   localparam logic [KLEN_BITS-1:0] KLEN_RESET    = 4'd5;
   localparam logic [OUT_BITS-1:0]  OUT_COUNT_MAX = 20'hFFFFF;

   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [1:0] OP_NOP   = 2'd0;
   localparam logic [1:0] OP_INC   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   typedef struct packed {
      logic [1:0]             mode;
      logic [SYMBOL_BITS-1:0] symbol;
      logic [INDEX_BITS-1:0]  bin_index;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0]   bin_count;
      logic [INDEX_BITS-1:0] bin_echo;
   } rsp_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       in_range;
   } op_type;

endpackage

`default_nettype wire

// ----- rtl/kfc_window.sv -----
`default_nettype none

module kfc_window #(
   parameter int MAX_KMER = kfc_pkg::MAX_KMER_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   in_accept,
   input  kfc_pkg::req_type                      in_data,
   input  wire                                   csr_write,
   input  wire  [kfc_pkg::KLEN_BITS-1:0]         csr_value,
   output kfc_pkg::op_type                       op,
   output logic [2*MAX_KMER-1:0]                 op_addr
);

   localparam int AW = 2 * MAX_KMER;
   localparam int CW = (AW > kfc_pkg::INDEX_BITS) ? AW : kfc_pkg::INDEX_BITS;
   localparam int KB = kfc_pkg::KLEN_BITS;

   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   logic [KB-1:0] klen_ff, klen_in;
   logic [AW-1:0] code_ff, code_in;
   logic [KB-1:0] fill_ff, fill_in;

   logic [KB-1:0] eff_k;
   logic [AW:0]   kspan;
   logic [AW-1:0] kmask;
   logic          base_ok;
   logic [1:0]    base;
   logic [AW-1:0] shifted;
   logic [KB-1:0] fill_next;

   always_comb begin
      if (klen_ff == '0) begin
         eff_k = KB'(1);
      end else if (klen_ff > KB'(MAX_KMER)) begin
         eff_k = KB'(MAX_KMER);
      end else begin
         eff_k = klen_ff;
      end
      kspan = (AW + 1)'(1) << {eff_k, 1'b0};
      kmask = AW'(kspan - (AW + 1)'(1));
   end

   always_comb begin
      base_ok = 1'b1;
      unique case (in_data.symbol)
         CHAR_A:  base = 2'd0;
         CHAR_C:  base = 2'd1;
         CHAR_G:  base = 2'd2;
         CHAR_T:  base = 2'd3;
         default: begin
            base    = 2'd0;
            base_ok = 1'b0;
         end
      endcase
      shifted   = AW'({code_ff, base});
      fill_next = (fill_ff < KB'(MAX_KMER)) ? KB'(fill_ff + 1'b1) : fill_ff;
   end

   always_comb begin
      op.cmd      = kfc_pkg::OP_NOP;
      op.in_range = 1'b0;
      op_addr     = '0;
      code_in     = code_ff;
      fill_in     = fill_ff;
      klen_in     = csr_write ? csr_value : klen_ff;
      unique case (in_data.mode)
         kfc_pkg::MODE_PUSH: begin
            if (base_ok) begin
               code_in = shifted;
               fill_in = fill_next;
               if (fill_next >= eff_k) begin
                  op.cmd  = kfc_pkg::OP_INC;
                  op_addr = shifted & kmask;
               end
            end else begin
               code_in = '0;
               fill_in = '0;
            end
         end
         kfc_pkg::MODE_READ: begin
            op.cmd      = kfc_pkg::OP_READ;
            op.in_range = CW'(in_data.bin_index) <= CW'(kmask);
            op_addr     = AW'(in_data.bin_index);
         end
         kfc_pkg::MODE_CLEAR: begin
            op.cmd  = kfc_pkg::OP_CLEAR;
            code_in = '0;
            fill_in = '0;
         end
         default: begin
            op.cmd = kfc_pkg::OP_NOP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff <= kfc_pkg::KLEN_RESET;
         code_ff <= '0;
         fill_ff <= '0;
      end else begin
         klen_ff <= klen_in;
         if (in_accept) begin
            code_ff <= code_in;
            fill_ff <= fill_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/kfc_bin_store.sv -----
`default_nettype none

module kfc_bin_store #(
   parameter int MAX_KMER   = kfc_pkg::MAX_KMER_DEFAULT,
   parameter int COUNT_BITS = kfc_pkg::COUNT_BITS_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 in_accept,
   input  kfc_pkg::op_type                     in_op,
   input  wire  [2*MAX_KMER-1:0]               in_addr,
   input  wire  [kfc_pkg::INDEX_BITS-1:0]      in_echo,
   output logic                                in_ready,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output kfc_pkg::rsp_type                    rsp_data
);

   localparam int AW    = 2 * MAX_KMER;
   localparam int DEPTH = 1 << AW;
   localparam int OB    = kfc_pkg::OUT_BITS;

   logic [COUNT_BITS-1:0] mem [DEPTH];

   logic                          clr_busy_ff, clr_busy_in;
   logic [AW-1:0]                 clr_addr_ff, clr_addr_in;
   logic                          s1_valid_ff, s1_valid_in;
   kfc_pkg::op_type               s1_op_ff;
   logic [AW-1:0]                 s1_addr_ff;
   logic [kfc_pkg::INDEX_BITS-1:0] s1_echo_ff;
   logic                          fwd_valid_ff;
   logic [AW-1:0]                 fwd_addr_ff;
   logic [COUNT_BITS-1:0]         fwd_data_ff;
   logic [COUNT_BITS-1:0]         rd_data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   kfc_pkg::rsp_type              rsp_data_ff;

   logic                  s1_stall;
   logic                  s1_done;
   logic [COUNT_BITS-1:0] cur;
   logic [COUNT_BITS-1:0] bumped;
   logic [COUNT_BITS-1:0] seen;
   logic [COUNT_BITS-1:0] cnt_limit;
   logic [OB-1:0]         cnt_out;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [COUNT_BITS-1:0] wr_data;

   always_comb begin
      s1_stall  = s1_valid_ff && (s1_op_ff.cmd == kfc_pkg::OP_READ) && rsp_valid_ff
                  && !rsp_ready;
      s1_done   = s1_valid_ff && !s1_stall;
      in_ready  = !clr_busy_ff && !s1_stall;
      cur       = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rd_data_ff;
      bumped    = (&cur) ? cur : COUNT_BITS'(cur + 1'b1);
      seen      = s1_op_ff.in_range ? cur : '0;
      cnt_limit = COUNT_BITS'(kfc_pkg::OUT_COUNT_MAX);
      cnt_out   = (seen > cnt_limit) ? kfc_pkg::OUT_COUNT_MAX : OB'(seen);

      priority if (clr_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_done && (s1_op_ff.cmd == kfc_pkg::OP_INC);
         wr_addr = s1_addr_ff;
         wr_data = bumped;
      end

      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (in_accept && (in_op.cmd == kfc_pkg::OP_CLEAR)) begin
         clr_busy_in = 1'b1;
         clr_addr_in = '0;
      end else if (clr_busy_ff) begin
         clr_addr_in = AW'(clr_addr_ff + 1'b1);
         if (&clr_addr_ff) begin
            clr_busy_in = 1'b0;
         end
      end

      s1_valid_in = in_accept ? 1'b1 : (s1_done ? 1'b0 : s1_valid_ff);

      if (s1_done && (s1_op_ff.cmd == kfc_pkg::OP_READ)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (in_accept) begin
         rd_data_ff <= mem[in_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_op_ff     <= in_op;
         s1_addr_ff   <= in_addr;
         s1_echo_ff   <= in_echo;
         fwd_valid_ff <= wr_en;
         fwd_addr_ff  <= wr_addr;
         fwd_data_ff  <= wr_data;
      end
      if (s1_done && (s1_op_ff.cmd == kfc_pkg::OP_READ)) begin
         rsp_data_ff.bin_count <= cnt_out;
         rsp_data_ff.bin_echo  <= s1_echo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/kmer_frequency_counter.sv -----
// A read's count passes a lookup register, then a response register that waits on rsp_ready.
// Pushes, reads and clears are accepted one beat per cycle while req_ready is high;
// back-to-back pushes to one bin are forwarded around the read-modify-write of the bin memory.
// Reset and every clear beat sweep all 4^MAX_KMER entries (65536 by default) of the bin memory,
// one entry per cycle, with req_ready low; csr writes are taken at any time.
// Reset is synchronous and active high; it sets the k-mer length to five and empties the window.
`default_nettype none

module kmer_frequency_counter #(
   parameter int MAX_KMER   = kfc_pkg::MAX_KMER_DEFAULT,
   parameter int COUNT_BITS = kfc_pkg::COUNT_BITS_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  kfc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output kfc_pkg::rsp_type               rsp_data,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire  [kfc_pkg::KLEN_BITS-1:0]  csr_data
);

   logic                  accept;
   kfc_pkg::op_type       op;
   logic [2*MAX_KMER-1:0] op_addr;
   logic                  store_ready;

   assign csr_ready = 1'b1;
   assign req_ready = store_ready;
   assign accept    = req_valid && store_ready;

   kfc_window #(
      .MAX_KMER (MAX_KMER)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_data   (req_data),
      .csr_write (csr_valid),
      .csr_value (csr_data),
      .op        (op),
      .op_addr   (op_addr)
   );

   kfc_bin_store #(
      .MAX_KMER   (MAX_KMER),
      .COUNT_BITS (COUNT_BITS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_op     (op),
      .in_addr   (op_addr),
      .in_echo   (req_data.bin_index),
      .in_ready  (store_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/kfc_checker.sv -----
`default_nettype none

module kfc_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_valid,
   input wire                            req_ready,
   input kfc_pkg::req_type               req_data,
   input wire                            rsp_valid,
   input wire                            rsp_ready,
   input kfc_pkg::rsp_type               rsp_data,
   input wire                            csr_valid,
   input wire                            csr_ready,
   input wire [kfc_pkg::KLEN_BITS-1:0]   csr_data
);

   logic unused_ports;
   assign unused_ports = csr_valid ^ csr_ready ^ (^csr_data);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response beat changed or dropped.");

   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("Request taken while the post-reset clear is running.");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response beat present right after reset.");

   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.mode == kfc_pkg::MODE_CLEAR) |=> !req_ready)
      else $error("Request taken right after a clear beat.");

endmodule

bind kmer_frequency_counter kfc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_data  (csr_data)
);

`default_nettype wire
